// ===== src/svfe_pkg.sv =====
// ----------------------------------------------------------------------------
// svfe_pkg
// Shared constants, byte selects and control/status types for the serial
// value frame encoder.
// ----------------------------------------------------------------------------
package svfe_pkg;

  function automatic int dec_digits(input int bits);
    longint v;
    int     n;
    v = longint'(1) << (bits - 1);
    n = 0;
    while (v > 0) begin
      v = v / 10;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int VALUE_BITS  = 16;
  localparam int MAX_ENTRIES = 9;
  localparam int FIELD_COUNT = 5;
  localparam int DEC_DIGITS  = dec_digits(VALUE_BITS);
  localparam int BCD_BITS    = 4 * DEC_DIGITS;
  localparam int SEQ_DIGITS  = 3;
  localparam int SEQ_BITS    = 4 * SEQ_DIGITS;
  localparam int CNT_W       = $clog2(VALUE_BITS);

  localparam logic [7:0] ASCII_S     = 8'h53;
  localparam logic [7:0] ASCII_P     = 8'h50;
  localparam logic [7:0] ASCII_T     = 8'h54;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_V     = 8'h76;
  localparam logic [7:0] ASCII_A     = 8'h61;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  localparam logic [2:0] SEL_KIND  = 3'd0;
  localparam logic [2:0] SEL_SEQ   = 3'd1;
  localparam logic [2:0] SEL_ENTRY = 3'd2;
  localparam logic [2:0] SEL_FIELD = 3'd3;
  localparam logic [2:0] SEL_DIGIT = 3'd4;
  localparam logic [2:0] SEL_SIGN  = 3'd5;
  localparam logic [2:0] SEL_TRAIL = 3'd6;

  typedef struct packed {
    logic       load;
    logic       conv_step;
    logic       dig_shift;
    logic       seq_shift;
    logic       emit;
    logic [2:0] sel;
    logic       run_end;
  } ctrl_t;

  typedef struct packed {
    logic has_hdr;
    logic has_val;
    logic has_t;
    logic digit_zero;
    logic out_free;
  } stat_t;

endpackage

// ===== src/svfe_datapath.sv =====
// ----------------------------------------------------------------------------
// svfe_datapath
// Item registers, BCD sequence counters, binary-to-BCD shifter and the
// output register.
// ----------------------------------------------------------------------------
module svfe_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [3:0]                            cfg_data,
  input  logic                                  in_frame_kind,
  input  logic [3:0]                            in_entry_index,
  input  logic [2:0]                            in_field_index,
  input  logic signed [svfe_pkg::VALUE_BITS-1:0] in_value,
  input  logic                                  in_first_slot,
  input  logic                                  in_last_slot,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [7:0]                            out_byte,
  output logic                                  out_run_end,
  input  svfe_pkg::ctrl_t                       cmd,
  output svfe_pkg::stat_t                       stat
);

  logic [3:0]                      entries_r;
  logic [svfe_pkg::SEQ_BITS-1:0]   s_seq_r;
  logic [svfe_pkg::SEQ_BITS-1:0]   p_seq_r;
  logic [svfe_pkg::SEQ_BITS-1:0]   seq_sh_r;
  logic [svfe_pkg::SEQ_BITS-1:0]   seq_inc;
  logic [svfe_pkg::SEQ_BITS-1:0]   seq_sel;
  logic                            kind_r;
  logic [3:0]                      entry_r;
  logic [2:0]                      field_r;
  logic                            neg_r;
  logic [svfe_pkg::VALUE_BITS-1:0] mag_r;
  logic [svfe_pkg::VALUE_BITS-1:0] mag_in;
  logic [svfe_pkg::BCD_BITS-1:0]   bcd_r;
  logic [svfe_pkg::BCD_BITS-1:0]   bcd_adj;
  logic                            has_hdr_r;
  logic                            has_val_r;
  logic                            has_t_r;
  logic                            in_use;
  logic                            val_in;
  logic                            out_valid_r;
  logic [7:0]                      out_byte_r;
  logic                            run_end_r;
  logic [7:0]                      byte_nxt;
  logic                            carry;

  assign seq_sel = in_frame_kind ? p_seq_r : s_seq_r;

  always_comb begin
    carry = 1'b1;
    for (int i = 0; i < svfe_pkg::SEQ_DIGITS; i++) begin
      if (carry && seq_sel[4*i +: 4] == 4'd9) begin
        seq_inc[4*i +: 4] = 4'd0;
      end else begin
        seq_inc[4*i +: 4] = seq_sel[4*i +: 4] + {3'b000, carry};
        carry = 1'b0;
      end
    end
  end

  assign mag_in = in_value[svfe_pkg::VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
  assign in_use = in_frame_kind ||
                  (({1'b0, in_entry_index} < {1'b0, entries_r}) &&
                   ({1'b0, in_entry_index} < 5'(svfe_pkg::MAX_ENTRIES)));
  assign val_in = (in_value != '0) && in_use &&
                  ({1'b0, in_field_index} < 4'(svfe_pkg::FIELD_COUNT));

  always_comb begin
    for (int i = 0; i < svfe_pkg::DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    case (cmd.sel)
      svfe_pkg::SEL_KIND:  byte_nxt = kind_r ? svfe_pkg::ASCII_P : svfe_pkg::ASCII_S;
      svfe_pkg::SEL_SEQ:   byte_nxt = {svfe_pkg::ASCII_DIGIT_HI,
                                       seq_sh_r[svfe_pkg::SEQ_BITS-1 -: 4]};
      svfe_pkg::SEL_ENTRY: byte_nxt = svfe_pkg::ASCII_A + {4'b0000, entry_r};
      svfe_pkg::SEL_FIELD: byte_nxt = svfe_pkg::ASCII_V + {5'b00000, field_r};
      svfe_pkg::SEL_DIGIT: byte_nxt = {svfe_pkg::ASCII_DIGIT_HI,
                                       bcd_r[svfe_pkg::BCD_BITS-1 -: 4]};
      svfe_pkg::SEL_SIGN:  byte_nxt = neg_r ? svfe_pkg::ASCII_MINUS : svfe_pkg::ASCII_PLUS;
      svfe_pkg::SEL_TRAIL: byte_nxt = svfe_pkg::ASCII_T;
      default:             byte_nxt = svfe_pkg::ASCII_T;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r   <= 4'(svfe_pkg::MAX_ENTRIES);
      s_seq_r     <= '0;
      p_seq_r     <= '0;
      has_hdr_r   <= 1'b0;
      has_val_r   <= 1'b0;
      has_t_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        entries_r <= cfg_data;
      end
      if (cmd.load) begin
        has_hdr_r <= in_first_slot;
        has_val_r <= val_in;
        has_t_r   <= in_last_slot;
        if (in_first_slot) begin
          if (in_frame_kind) begin
            p_seq_r <= seq_inc;
          end else begin
            s_seq_r <= seq_inc;
          end
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_frame_kind;
      entry_r  <= in_frame_kind ? 4'd0 : in_entry_index;
      field_r  <= in_field_index;
      neg_r    <= in_value[svfe_pkg::VALUE_BITS-1];
      mag_r    <= mag_in;
      bcd_r    <= '0;
      seq_sh_r <= seq_sel;
    end else begin
      if (cmd.conv_step) begin
        bcd_r <= {bcd_adj[svfe_pkg::BCD_BITS-2:0], mag_r[svfe_pkg::VALUE_BITS-1]};
        mag_r <= {mag_r[svfe_pkg::VALUE_BITS-2:0], 1'b0};
      end else if (cmd.dig_shift) begin
        bcd_r <= {bcd_r[svfe_pkg::BCD_BITS-5:0], 4'd0};
      end
      if (cmd.seq_shift) begin
        seq_sh_r <= {seq_sh_r[svfe_pkg::SEQ_BITS-5:0], 4'd0};
      end
    end
    if (cmd.emit) begin
      out_byte_r <= byte_nxt;
      run_end_r  <= cmd.run_end;
    end
  end

  assign stat.has_hdr    = has_hdr_r;
  assign stat.has_val    = has_val_r;
  assign stat.has_t      = has_t_r;
  assign stat.digit_zero = (bcd_r[svfe_pkg::BCD_BITS-1 -: 4] == 4'd0);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_run_end = run_end_r;

endmodule

// ===== src/svfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// svfe_ctrl
// Sequencer for one transaction: dispatch, conversion, header, value
// letters, digits, sign and trailer.
// ----------------------------------------------------------------------------
module svfe_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  svfe_pkg::stat_t stat,
  output svfe_pkg::ctrl_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_CONV = 4'd2;
  localparam logic [3:0] S_HDR  = 4'd3;
  localparam logic [3:0] S_ENT  = 4'd4;
  localparam logic [3:0] S_FLD  = 4'd5;
  localparam logic [3:0] S_SKIP = 4'd6;
  localparam logic [3:0] S_DIG  = 4'd7;
  localparam logic [3:0] S_SIGN = 4'd8;
  localparam logic [3:0] S_TRL  = 4'd9;

  logic [3:0]                 state_r;
  logic [3:0]                 state_nxt;
  logic [svfe_pkg::CNT_W-1:0] cnt_r;
  logic [svfe_pkg::CNT_W-1:0] cnt_nxt;
  logic [3:0]                 after_val;

  assign in_ready  = (state_r == S_IDLE);
  assign after_val = stat.has_t ? S_TRL : S_IDLE;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.sel       = svfe_pkg::SEL_TRAIL;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
          cnt_nxt   = '0;
        end
      end
      S_DISP: begin
        if (stat.has_val) begin
          state_nxt = S_CONV;
        end else if (stat.has_hdr) begin
          state_nxt = S_HDR;
        end else begin
          state_nxt = after_val;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (cnt_r == svfe_pkg::CNT_W'(svfe_pkg::VALUE_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = stat.has_hdr ? S_HDR : S_ENT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_HDR: begin
        cmd.sel = (cnt_r == '0) ? svfe_pkg::SEL_KIND : svfe_pkg::SEL_SEQ;
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.seq_shift = (cnt_r != '0);
          if (cnt_r == svfe_pkg::CNT_W'(svfe_pkg::SEQ_DIGITS)) begin
            cmd.run_end = !stat.has_val && !stat.has_t;
            cnt_nxt     = '0;
            state_nxt   = stat.has_val ? S_ENT : after_val;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_ENT: begin
        cmd.sel = svfe_pkg::SEL_ENTRY;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_FLD;
        end
      end
      S_FLD: begin
        cmd.sel = svfe_pkg::SEL_FIELD;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (stat.digit_zero && cnt_r != svfe_pkg::CNT_W'(svfe_pkg::DEC_DIGITS - 1)) begin
          cmd.dig_shift = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
        end else begin
          state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        cmd.sel = svfe_pkg::SEL_DIGIT;
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.dig_shift = 1'b1;
          if (cnt_r == svfe_pkg::CNT_W'(svfe_pkg::DEC_DIGITS - 1)) begin
            cnt_nxt   = '0;
            state_nxt = S_SIGN;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_SIGN: begin
        cmd.sel = svfe_pkg::SEL_SIGN;
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.run_end = !stat.has_t;
          state_nxt   = after_val;
        end
      end
      S_TRL: begin
        cmd.sel = svfe_pkg::SEL_TRAIL;
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.run_end = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free) else $error("byte emitted into a full output register");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.run_end) |=> (state_r == S_IDLE))
    else $error("sequencer busy after final byte");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE)) else $error("load outside idle");

  a_hdr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HDR) |-> (cnt_r <= svfe_pkg::CNT_W'(svfe_pkg::SEQ_DIGITS)))
    else $error("header counter out of range");
`endif

endmodule

// ===== src/serial_value_frame_encoder_top.sv =====
// Sequence: a dispatch state after the accepting edge, then binary-to-BCD shifting of all VALUE_BITS (16)
// bits for a value that is emitted, then skipping of leading zeros.
// Throughput: one byte per cycle while out_ready is high, outside the conversion and zero-skip states;
// in_ready only when idle, so a slot is taken once the last one has emitted its bytes (at most 13).
// Reset: rst_n synchronous, active low; both sequence counters clear, entries_r reads 9.
// ----------------------------------------------------------------------------
// serial_value_frame_encoder_top
// Encodes one value slot per transaction into the ASCII frame byte stream.
// ----------------------------------------------------------------------------
module serial_value_frame_encoder_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [3:0]                            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_frame_kind,
  input  logic [3:0]                            in_entry_index,
  input  logic [2:0]                            in_field_index,
  input  logic signed [svfe_pkg::VALUE_BITS-1:0] in_value,
  input  logic                                  in_first_slot,
  input  logic                                  in_last_slot,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [7:0]                            out_byte,
  output logic                                  out_run_end
);

  svfe_pkg::ctrl_t cmd;
  svfe_pkg::stat_t stat;

  svfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  svfe_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_frame_kind  (in_frame_kind),
    .in_entry_index (in_entry_index),
    .in_field_index (in_field_index),
    .in_value       (in_value),
    .in_first_slot  (in_first_slot),
    .in_last_slot   (in_last_slot),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

// ===== sim/tb_serial_value_frame_encoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_serial_value_frame_encoder_top
// Self-checking regression for the serial value frame encoder. Value slots
// are offered in random bursts; an in-bench predictor keeps its own sequence
// counters and entry setting and queues the expected frame bytes, which are
// checked against every output transaction under a stalling receiver.
// ----------------------------------------------------------------------------
module tb_serial_value_frame_encoder_top;

  localparam logic KIND_S = 1'b0;
  localparam logic KIND_P = 1'b1;

  localparam int READY_FREE     = 0;
  localparam int READY_RANDOM   = 1;
  localparam int READY_PERIODIC = 2;

  localparam int SEQ_WRAP      = 1000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_SLOTS  = 437;
  localparam int LIMIT_CYCLES  = 600000;

  typedef struct packed {
    logic                                  frame_kind;
    logic [3:0]                            entry_index;
    logic [2:0]                            field_index;
    logic signed [svfe_pkg::VALUE_BITS-1:0] value;
    logic                                  first_slot;
    logic                                  last_slot;
  } slot_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
  } frame_byte_t;

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  cfg_we = 1'b0;
  logic [3:0]                            cfg_data = '0;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic                                  in_frame_kind = 1'b0;
  logic [3:0]                            in_entry_index = '0;
  logic [2:0]                            in_field_index = '0;
  logic signed [svfe_pkg::VALUE_BITS-1:0] in_value = '0;
  logic                                  in_first_slot = 1'b0;
  logic                                  in_last_slot = 1'b0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic [7:0]                            out_byte;
  logic                                  out_run_end;

  frame_byte_t expected_bytes[$];
  logic [9:0]  s_seq = '0;
  logic [9:0]  p_seq = '0;
  logic [3:0]  entries_cfg = 4'd9;

  int mismatches    = 0;
  int slots_sent    = 0;
  int burst_left    = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int ready_mode    = READY_FREE;
  int phase_left    = 0;
  int ready_tick    = 0;
  int cycle_count   = 0;

  serial_value_frame_encoder_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_frame_kind  (in_frame_kind),
    .in_entry_index (in_entry_index),
    .in_field_index (in_field_index),
    .in_value       (in_value),
    .in_first_slot  (in_first_slot),
    .in_last_slot   (in_last_slot),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end)
  );

  always #5 clk = ~clk;

  function automatic slot_t make_slot(input logic kind, input int entry, input int field,
                                      input int value, input logic first, input logic last);
    slot_t s;
    s.frame_kind  = kind;
    s.entry_index = 4'(entry);
    s.field_index = 3'(field);
    s.value       = svfe_pkg::VALUE_BITS'(value);
    s.first_slot  = first;
    s.last_slot   = last;
    return s;
  endfunction

  // Bytes that one slot adds to the frame stream; a first slot advances the sequence counter of its kind.
  function automatic void predict_frame_bytes(input slot_t s);
    logic [7:0]  run[$];
    logic [7:0]  digs[$];
    int unsigned seq;
    int unsigned mag;
    logic        in_use;
    logic [3:0]  entry;
    if (s.first_slot) begin
      seq = (s.frame_kind == KIND_P) ? p_seq : s_seq;
      run.push_back((s.frame_kind == KIND_P) ? svfe_pkg::ASCII_P : svfe_pkg::ASCII_S);
      run.push_back({svfe_pkg::ASCII_DIGIT_HI, 4'(seq / 100)});
      run.push_back({svfe_pkg::ASCII_DIGIT_HI, 4'((seq / 10) % 10)});
      run.push_back({svfe_pkg::ASCII_DIGIT_HI, 4'(seq % 10)});
      seq = (seq + 1 == SEQ_WRAP) ? 0 : seq + 1;
      if (s.frame_kind == KIND_P) p_seq = 10'(seq);
      else s_seq = 10'(seq);
    end
    entry  = (s.frame_kind == KIND_P) ? 4'd0 : s.entry_index;
    in_use = (s.frame_kind == KIND_P) ||
             (s.entry_index < entries_cfg && s.entry_index < svfe_pkg::MAX_ENTRIES);
    if (s.value != 0 && in_use && s.field_index < svfe_pkg::FIELD_COUNT) begin
      run.push_back(svfe_pkg::ASCII_A + 8'(entry));
      run.push_back(svfe_pkg::ASCII_V + 8'(s.field_index));
      mag = s.value[svfe_pkg::VALUE_BITS-1] ? -int'(s.value) : int'(s.value);
      while (mag != 0) begin
        digs.push_front({svfe_pkg::ASCII_DIGIT_HI, 4'(mag % 10)});
        mag = mag / 10;
      end
      foreach (digs[i]) run.push_back(digs[i]);
      run.push_back(s.value[svfe_pkg::VALUE_BITS-1] ? svfe_pkg::ASCII_MINUS
                                                    : svfe_pkg::ASCII_PLUS);
    end
    if (s.last_slot) run.push_back(svfe_pkg::ASCII_T);
    foreach (run[i]) expected_bytes.push_back('{ch: run[i], run_end: (i == run.size() - 1)});
  endfunction

  function automatic int rand_value();
    int d;
    int lo;
    int hi;
    int mag;
    d   = $urandom_range(1, 5);
    lo  = 10 ** (d - 1);
    hi  = (d == 5) ? 32767 : 10 ** d - 1;
    mag = $urandom_range(hi, lo);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic send_slot(input slot_t s);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left = burst_left - 1;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_frame_kind  <= s.frame_kind;
    in_entry_index <= s.entry_index;
    in_field_index <= s.field_index;
    in_value       <= s.value;
    in_first_slot  <= s.first_slot;
    in_last_slot   <= s.last_slot;
    do @(posedge clk); while (!in_ready);
    predict_frame_bytes(s);
    slots_sent = slots_sent + 1;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_entries(input int n);
    wait_drain();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= 4'(n);
    @(negedge clk);
    cfg_we   <= 1'b0;
    entries_cfg = 4'(n);
  endtask

  task automatic test_directed_slots();
    send_slot(make_slot(KIND_S, 0, 0, 1, 1'b1, 1'b0));
    send_slot(make_slot(KIND_S, 8, 4, 32767, 1'b0, 1'b1));
    send_slot(make_slot(KIND_S, 4, 2, -32767, 1'b1, 1'b1));
    send_slot(make_slot(KIND_P, 8, 4, -1, 1'b1, 1'b0));
    send_slot(make_slot(KIND_P, 5, 1, 0, 1'b0, 1'b1));
    send_slot(make_slot(KIND_S, 2, 3, 0, 1'b0, 1'b0));
    send_slot(make_slot(KIND_S, 6, 0, 0, 1'b1, 1'b1));
    send_slot(make_slot(KIND_P, 3, 0, 10, 1'b1, 1'b1));
    send_slot(make_slot(KIND_S, 1, 1, 100, 1'b0, 1'b0));
    send_slot(make_slot(KIND_S, 5, 2, -10000, 1'b0, 1'b0));
    send_slot(make_slot(KIND_S, 7, 3, 9, 1'b0, 1'b0));
    send_slot(make_slot(KIND_P, 0, 2, 0, 1'b1, 1'b0));
    wait_drain();
  endtask

  task automatic test_entry_setting();
    write_entries(0);
    send_slot(make_slot(KIND_S, 0, 0, 5, 1'b1, 1'b0));
    send_slot(make_slot(KIND_P, 0, 1, 5, 1'b0, 1'b0));
    send_slot(make_slot(KIND_S, 8, 4, 5, 1'b0, 1'b1));
    write_entries(1);
    send_slot(make_slot(KIND_S, 0, 2, 7, 1'b0, 1'b0));
    send_slot(make_slot(KIND_S, 1, 2, -7, 1'b0, 1'b0));
    write_entries(8);
    send_slot(make_slot(KIND_S, 7, 3, 4321, 1'b0, 1'b0));
    send_slot(make_slot(KIND_S, 8, 3, 4321, 1'b0, 1'b1));
    write_entries(9);
    send_slot(make_slot(KIND_S, 8, 0, -256, 1'b0, 1'b0));
    wait_drain();
  endtask

  // Receiver holds off while the sender keeps offering, then the sender drains.
  task automatic test_output_backpressure();
    hold_requests = hold_requests + 1;
    burst_left = 12;
    for (int i = 0; i < 12; i++)
      send_slot(make_slot(1'($urandom_range(0, 1)), $urandom_range(0, 8),
                          $urandom_range(0, 4), rand_value(), (i % 4) == 0, (i % 4) == 3));
    wait_drain();
  endtask

  task automatic test_random_frames();
    int   target;
    int   n;
    slot_t s;
    target = slots_sent + RANDOM_SLOTS;
    while (slots_sent < target) begin
      if ($urandom_range(0, 11) == 0) write_entries($urandom_range(0, 9));
      if ($urandom_range(0, 6) == 0) begin
        s = make_slot(1'($urandom_range(0, 1)), $urandom_range(0, 8), $urandom_range(0, 4),
                      $urandom_range(0, 2) == 0 ? 0 : rand_value(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_slot(s);
      end else begin
        n = $urandom_range(1, 6);
        s.frame_kind = 1'($urandom_range(0, 1));
        for (int i = 0; i < n; i++) begin
          s = make_slot(s.frame_kind, $urandom_range(0, 8), $urandom_range(0, 4),
                        $urandom_range(0, 6) == 0 ? 0 : rand_value(), i == 0, i == n - 1);
          send_slot(s);
        end
      end
    end
    wait_drain();
  endtask

  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        ready_mode = $urandom_range(READY_FREE, READY_PERIODIC);
        phase_left = $urandom_range(20, 200);
      end
      phase_left = phase_left - 1;
      ready_tick = ready_tick + 1;
      case (ready_mode)
        READY_FREE:   out_ready <= 1'b1;
        READY_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default:      out_ready <= (ready_tick % 3 == 0);
      endcase
    end
  end

  task automatic note_mismatch(input string what, input frame_byte_t want);
    mismatches = mismatches + 1;
    if (mismatches <= 10)
      $display("mismatch (%s): expected byte %h run_end %b, got byte %h run_end %b",
               what, want.ch, want.run_end, out_byte, out_run_end);
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        note_mismatch("no transaction expected", '0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.ch || out_run_end !== want.run_end)
          note_mismatch("frame byte", want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("serial_value_frame_encoder_top regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_slots();
    test_entry_setting();
    test_output_backpressure();
    test_random_frames();
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("serial_value_frame_encoder_top regression: pass");
    end else begin
      $display("serial_value_frame_encoder_top regression: fail");
    end
    $finish;
  end

endmodule
